@@ src/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types, sizes and request codes for the sortable FIFO block.
// ----------------------------------------------------------------------------
package fqs_pkg;

  // Queue geometry; the occupancy field is CNT_W = 5 bits wide
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  // Request codes; the remaining code is a no-op
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_SORT = 2'd2;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     popped_valid;
    logic [CNT_W-1:0]         occupancy;
    logic                     empty_res;
    logic                     error;
  } out_word_t;

  // Status from the sequencer to the handshake logic
  typedef struct packed {
    logic idle;
    logic res_valid;
  } stat_t;

  // Memory port bundle from the sequencer to the entry store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_RUN  = 4'b0100,
    S_END  = 4'b1000
  } state_e;

  // Physical slot of logical position idx behind the head pointer
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ src/fifo_queue_with_sort_core.sv @@
// Push, no-op and rejected requests reach the output register in the cycle after acceptance;
// a pop passes the registered read of the entry memory and the pop state first.
// A sort of n elements runs bubble passes over L slots (L = n down to 2, ending early
// after a pass without exchange), each a run state and an end state, one memory slot a cycle.
// One request is in work at a time; the next is taken once idle and the output register is free.
// Reset clears the fill count, the head pointer and the output valid flag; memory is not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_with_sort_core
// Bounded FIFO of signed words with in-place ascending sort, memory based.
// ----------------------------------------------------------------------------
module fifo_queue_with_sort_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fqs_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fqs_pkg::out_word_t  out_word_o
);

  fqs_pkg::mem_req_t          mem_req;
  logic [fqs_pkg::DATA_W-1:0] rdata;
  fqs_pkg::stat_t             stat;
  fqs_pkg::out_word_t         res;
  logic                       out_free;
  logic                       accept;
  logic                       out_valid_q;
  fqs_pkg::out_word_t         out_word_q;

  // Output slot frees up when it is empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(stat.idle && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  fqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .rdata_i   (rdata),
    .mem_req_o (mem_req),
    .stat_o    (stat),
    .res_o     (res)
  );

  fqs_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_valid |-> out_free)
    else $error("result overwrites a waiting word");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.idle |-> in_stall_o)
    else $error("input taken while a request is in work");

  a_pop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.popped_valid) |-> !out_word_q.error)
    else $error("popped word flagged as error");

endmodule

@@ src/fqs_mem.sv @@
// ----------------------------------------------------------------------------
// fqs_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fqs_mem (
  input  logic                         clk_i,
  input  fqs_pkg::mem_req_t            req_i,
  output logic [fqs_pkg::DATA_W-1:0]   rdata_o
);

  logic [fqs_pkg::DATA_W-1:0] mem_q [fqs_pkg::DEPTH];
  logic [fqs_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fqs_ctrl
// Request sequencer: ring head pointer, fill count and the bubble-sort passes
// that read, compare and write back the entry store one slot a cycle.
// ----------------------------------------------------------------------------
module fqs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  fqs_pkg::in_word_t           in_word_i,
  input  logic [fqs_pkg::DATA_W-1:0]  rdata_i,
  output fqs_pkg::mem_req_t           mem_req_o,
  output fqs_pkg::stat_t              stat_o,
  output fqs_pkg::out_word_t          res_o
);

  localparam int unsigned IW = fqs_pkg::IDX_W;
  localparam int unsigned CW = fqs_pkg::CNT_W;

  fqs_pkg::state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] j_q, j_d;
  logic [CW-1:0] lim_q, lim_d;
  logic          swap_q, swap_d;
  logic signed [fqs_pkg::DATA_W-1:0] held_q, held_d;
  logic signed [fqs_pkg::DATA_W-1:0] rd_s;
  logic [CW-1:0] lim_m1;

  assign rd_s   = $signed(rdata_i);
  assign lim_m1 = lim_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    j_d       = j_q;
    lim_d     = lim_q;
    swap_d    = swap_q;
    held_d    = held_q;
    mem_req_o = '{we: 1'b0, waddr: head_q, wdata: '0, raddr: head_q};
    stat_o    = '{idle: (state_q == fqs_pkg::S_IDLE), res_valid: 1'b0};
    res_o     = '0;

    case (state_q)
      fqs_pkg::S_IDLE: begin
        if (accept_i) begin
          case (in_word_i.operation)
            fqs_pkg::OP_PUSH: begin
              stat_o.res_valid = 1'b1;
              if (count_q == CW'(fqs_pkg::DEPTH)) begin
                res_o.error = 1'b1;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = fqs_pkg::phys(head_q, count_q[IW-1:0]);
                mem_req_o.wdata = in_word_i.value;
                count_d         = count_q + CW'(1);
              end
            end
            fqs_pkg::OP_POP: begin
              if (count_q == '0) begin
                stat_o.res_valid = 1'b1;
                res_o.error      = 1'b1;
              end else begin
                state_d = fqs_pkg::S_POP;
              end
            end
            fqs_pkg::OP_SORT: begin
              if (count_q < CW'(2)) begin
                stat_o.res_valid = 1'b1;
              end else begin
                j_d     = '0;
                lim_d   = count_q;
                swap_d  = 1'b0;
                state_d = fqs_pkg::S_RUN;
              end
            end
            default: begin
              stat_o.res_valid = 1'b1;
            end
          endcase
        end
      end

      fqs_pkg::S_POP: begin
        stat_o.res_valid   = 1'b1;
        res_o.popped_value = rd_s;
        res_o.popped_valid = 1'b1;
        head_d             = fqs_pkg::phys(head_q, IW'(1));
        count_d            = count_q - CW'(1);
        state_d            = fqs_pkg::S_IDLE;
      end

      fqs_pkg::S_RUN: begin
        // Hold the larger value, write the smaller one back one slot behind
        if (j_q == '0) begin
          held_d = rd_s;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = fqs_pkg::phys(head_q, j_q - IW'(1));
          if (held_q > rd_s) begin
            mem_req_o.wdata = rd_s;
            swap_d          = 1'b1;
          end else begin
            mem_req_o.wdata = held_q;
            held_d          = rd_s;
          end
        end
        if (CW'(j_q) + CW'(1) == lim_q) begin
          state_d = fqs_pkg::S_END;
        end else begin
          j_d             = j_q + IW'(1);
          mem_req_o.raddr = fqs_pkg::phys(head_q, j_q + IW'(1));
        end
      end

      fqs_pkg::S_END: begin
        // Drop the pass maximum into the last slot of the pass
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = fqs_pkg::phys(head_q, lim_m1[IW-1:0]);
        mem_req_o.wdata = held_q;
        if (swap_q && (lim_m1 > CW'(1))) begin
          lim_d   = lim_m1;
          j_d     = '0;
          swap_d  = 1'b0;
          state_d = fqs_pkg::S_RUN;
        end else begin
          stat_o.res_valid = 1'b1;
          state_d          = fqs_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fqs_pkg::S_IDLE;
      end
    endcase

    res_o.occupancy = count_d;
    res_o.empty_res = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqs_pkg::S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      j_q     <= '0;
      lim_q   <= '0;
      swap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      j_q     <= j_d;
      lim_q   <= lim_d;
      swap_q  <= swap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(fqs_pkg::DEPTH))
    else $error("fill count above depth");

  a_pass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fqs_pkg::S_RUN) |-> (lim_q >= CW'(2)) && (CW'(j_q) < lim_q)
                                    && (lim_q <= count_q))
    else $error("sort pass index out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fqs_pkg::S_POP) |-> (count_q != '0))
    else $error("pop issued on empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fqs_pkg::S_IDLE && accept_i && in_word_i.operation == fqs_pkg::OP_PUSH
     && count_q != CW'(fqs_pkg::DEPTH)) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the queue");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sortable FIFO core. A queue of request words
// (pushes, pops, sorts, no-ops) feeds a clocked driver. A clocked monitor
// runs a local queue model on every accepted request and compares each
// result word with the oldest prediction. Sender and receiver idle at random
// in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_top;

  // Unused request code, handled by the core as a no-op
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int unsigned RAND_ITEMS = 830;
  localparam int unsigned NUM_PHASES = 3;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TIMEOUT_NS = 5_000_000;

  typedef struct {
    fqs_pkg::in_word_t word;
    int unsigned       phase;
    bit                drain;
  } req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fqs_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fqs_pkg::out_word_t out_word;

  req_t               pending_reqs[$];
  fqs_pkg::out_word_t expected_words[$];
  int unsigned        total_reqs = 0;
  int unsigned        accepted_cnt = 0;
  int unsigned        mismatch_cnt = 0;
  int unsigned        cur_phase = 0;
  bit                 word_taken = 1'b0;

  int unsigned send_idle_pct[NUM_PHASES] = '{21, 63, 0};
  int unsigned recv_idle_pct[NUM_PHASES] = '{63, 21, 0};

  // Local copy of the queue contents, front at slot 0
  logic signed [fqs_pkg::DATA_W-1:0] model_slots[fqs_pkg::DEPTH];
  int unsigned                       model_fill = 0;

  fifo_queue_with_sort_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #4 clk_i = ~clk_i;

  // Apply one request to the queue model and return the result word it yields
  function automatic fqs_pkg::out_word_t fifo_apply(input fqs_pkg::in_word_t w);
    fqs_pkg::out_word_t                r;
    logic signed [fqs_pkg::DATA_W-1:0] tmp;
    int unsigned                       lim;
    bit                                swapped;
    r = '0;
    case (w.operation)
      fqs_pkg::OP_PUSH: begin
        if (model_fill >= fqs_pkg::DEPTH) begin
          r.error = 1'b1;
        end else begin
          model_slots[model_fill] = w.value;
          model_fill++;
        end
      end
      fqs_pkg::OP_POP: begin
        if (model_fill == 0) begin
          r.error = 1'b1;
        end else begin
          r.popped_value = model_slots[0];
          r.popped_valid = 1'b1;
          for (int i = 0; i + 1 < model_fill; i++) begin
            model_slots[i] = model_slots[i + 1];
          end
          model_fill--;
        end
      end
      fqs_pkg::OP_SORT: begin
        // bubble passes; equal neighbors stay in place
        lim = model_fill;
        swapped = 1'b1;
        while (swapped && lim > 1) begin
          swapped = 1'b0;
          for (int i = 0; i + 1 < lim; i++) begin
            if (model_slots[i] > model_slots[i + 1]) begin
              tmp = model_slots[i];
              model_slots[i] = model_slots[i + 1];
              model_slots[i + 1] = tmp;
              swapped = 1'b1;
            end
          end
          lim--;
        end
      end
      default: ;
    endcase
    r.occupancy = (fqs_pkg::CNT_W)'(model_fill);
    r.empty_res = (model_fill == 0);
    return r;
  endfunction

  function automatic logic signed [fqs_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2, 3: return $signed($urandom_range(8)) - 4;  // narrow range, many equal values
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [1:0] op,
                         input logic signed [fqs_pkg::DATA_W-1:0] val,
                         input int unsigned ph, input bit drain);
    req_t r;
    r.word.operation = op;
    r.word.value = val;
    r.phase = ph;
    r.drain = drain;
    pending_reqs = {pending_reqs, r};
    total_reqs++;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Driver: hold the word until taken, then advance to the next pending one
  always @(negedge clk_i) begin
    req_t nxt;
    if (rst_ni) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct[cur_phase]);
      if (!in_valid || word_taken) begin
        if (pending_reqs.size() != 0
            && !(pending_reqs[0].drain && expected_words.size() != 0)
            && $urandom_range(99) >= send_idle_pct[pending_reqs[0].phase]) begin
          nxt = pending_reqs[0];
          pending_reqs.delete(0);
          cur_phase = nxt.phase;
          in_word <= nxt.word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on request handshake, check on result handshake
  always @(posedge clk_i) begin
    fqs_pkg::out_word_t want;
    fqs_pkg::out_word_t pred;
    word_taken = rst_ni && in_valid && !in_stall;
    if (word_taken) begin
      pred = fifo_apply(in_word);
      expected_words = {expected_words, pred};
      accepted_cnt++;
    end
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %p", out_word));
      end else begin
        want = expected_words[0];
        expected_words.delete(0);
        if (out_word.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped_value got %h expected %h",
                                    out_word.popped_value, want.popped_value));
        if (out_word.popped_valid !== want.popped_valid)
          report_mismatch($sformatf("popped_valid got %b expected %b",
                                    out_word.popped_valid, want.popped_valid));
        if (out_word.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy got %0d expected %0d",
                                    out_word.occupancy, want.occupancy));
        if (out_word.empty_res !== want.empty_res)
          report_mismatch($sformatf("empty_res got %b expected %b",
                                    out_word.empty_res, want.empty_res));
        if (out_word.error !== want.error)
          report_mismatch($sformatf("error got %b expected %b",
                                    out_word.error, want.error));
      end
    end
  end

  initial begin
    int unsigned seg_left;
    int unsigned roll;
    int unsigned ph;
    int unsigned prev_ph;
    bit          push_heavy;
    logic [1:0]  op;

    // Directed: empty cases, extremes, fill to full, overflow, sort with duplicates
    add_req(fqs_pkg::OP_POP, 32'sh0, 0, 1'b0);
    add_req(OP_NOP, 32'shffffffff, 0, 1'b0);
    add_req(fqs_pkg::OP_SORT, 32'sh0, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh7fffffff, 0, 1'b0);
    add_req(fqs_pkg::OP_SORT, 32'sh0, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh80000000, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, -32'sd1, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh0, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh1, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh80000000, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh7fffffff, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'shaaaaaaaa, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh55555555, 0, 1'b0);
    for (int i = 0; i < 7; i++) add_req(fqs_pkg::OP_PUSH, rand_value(), 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh12345678, 0, 1'b0);
    add_req(fqs_pkg::OP_SORT, 32'sh0, 0, 1'b0);
    add_req(fqs_pkg::OP_POP, 32'sh0, 0, 1'b0);
    add_req(OP_NOP, 32'sh0, 0, 1'b0);
    add_req(fqs_pkg::OP_PUSH, 32'sh7fffffff, 0, 1'b0);

    // Random: alternate push-heavy and pop-heavy stretches to reach full and empty
    seg_left = 0;
    push_heavy = 1'b0;
    prev_ph = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        push_heavy = !push_heavy;
        seg_left = $urandom_range(60, 10);
      end
      seg_left--;
      ph = n * NUM_PHASES / RAND_ITEMS;
      roll = $urandom_range(99);
      if (roll < 8) op = fqs_pkg::OP_SORT;
      else if (roll < 11) op = OP_NOP;
      else if (roll < (push_heavy ? 81 : 31)) op = fqs_pkg::OP_PUSH;
      else op = fqs_pkg::OP_POP;
      add_req(op, rand_value(), ph, (ph != prev_ph) || ($urandom_range(99) == 0));
      prev_ph = ph;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_cnt != total_reqs || expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
src/fqs_pkg.sv
src/fqs_mem.sv
src/fqs_ctrl.sv
src/fifo_queue_with_sort_core.sv
sim/tb_top.sv
